/* hw/rtl/ilha_pkg.sv */
// Shared constants and types of the first-fit heap allocator.
package ilha_pkg;

    localparam int HEAP_WORDS_DEF = 1024;
    localparam int HDR_W          = 14;
    localparam int CFG_W          = 14;
    localparam int SIZE_W         = 16;
    localparam int OFF_W          = 13;
    localparam int RND_W          = 17;

    localparam logic [HDR_W-1:0] LEN_MASK  = 14'h3FF8;
    localparam logic [HDR_W-1:0] MIN_SPLIT = 14'd16;
    localparam logic [CFG_W-1:0] CFG_RESET = 14'd8192;

    typedef enum logic [2:0] {
        REQ_INIT    = 3'd0,
        REQ_ALLOC   = 3'd1,
        REQ_FREE    = 3'd2,
        REQ_REALLOC = 3'd3,
        REQ_CHECK   = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_TOO_SMALL = 2'd2,
        ST_CORRUPT   = 2'd3
    } t_status;

    typedef struct packed {
        logic [OFF_W-1:0] result_offset;
        logic [OFF_W-1:0] copy_bytes;
        logic [1:0]       status;
    } t_resp;

endpackage

/* hw/rtl/ilha_ram.sv */
// Generic simple dual-port RAM with registered read.
module ilha_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/ilha_core.sv */
// Request sequencer: header walks, splits and flag updates on the header RAM.
module ilha_core import ilha_pkg::*; #(
    parameter int HEAP_WORDS = HEAP_WORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2:0]                    i_req_type,
    input  logic [SIZE_W-1:0]             i_req_size,
    input  logic [OFF_W-1:0]              i_block_offset,
    input  logic [CFG_W-1:0]              i_cfg_len,
    input  logic                          i_slot_free,
    output logic                          o_done,
    output t_resp                         o_resp,
    output logic                          o_we,
    output logic [$clog2(HEAP_WORDS)-1:0] o_waddr,
    output logic [HDR_W-1:0]              o_wdata,
    output logic [$clog2(HEAP_WORDS)-1:0] o_raddr,
    input  logic [HDR_W-1:0]              i_rdata
);
    localparam int IW = $clog2(HEAP_WORDS);
    localparam int PW = (IW + 4 > 16) ? IW + 4 : 16;
    localparam logic [PW-1:0] CAP    = PW'(HEAP_WORDS * 8);
    localparam logic [PW:0]   CAP_W  = (PW+1)'(HEAP_WORDS * 8);
    localparam logic [IW-1:0] LAST   = IW'(HEAP_WORDS - 1);

    typedef enum logic [8:0] {
        S_CLR    = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_OLD_EV = 9'b000000100,
        S_WALK   = 9'b000001000,
        S_WEVAL  = 9'b000010000,
        S_SPLIT  = 9'b000100000,
        S_REL_RD = 9'b001000000,
        S_REL_WR = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [2:0]       r_type, n_type;
    logic [RND_W-1:0] r_rnd, n_rnd;
    logic [IW-1:0]    r_oidx, n_oidx;
    logic             r_have_old, n_have_old;
    logic [HDR_W-1:0] r_move, n_move;
    logic [PW-1:0]    r_pos, n_pos;
    logic [IW-1:0]    r_sidx, n_sidx;
    logic [HDR_W-1:0] r_sval, n_sval;
    logic [OFF_W-1:0] r_res, n_res;
    logic [OFF_W-1:0] r_copy, n_copy;
    logic [1:0]       r_status, n_status;
    logic [IW-1:0]    r_clr, n_clr;

    logic [PW-1:0]    w_cfg, w_len, w_offw;
    logic             w_off_ok;
    logic [IW-1:0]    w_oidx;
    logic [RND_W-1:0] w_rnd;
    logic [HDR_W-1:0] w_blen, w_rem;
    logic             w_fit;
    logic [PW:0]      w_sum;

    assign w_cfg    = PW'(i_cfg_len & LEN_MASK);
    assign w_len    = (w_cfg < CAP) ? w_cfg : CAP;
    assign w_offw   = PW'(i_block_offset);
    assign w_off_ok = (i_block_offset >= OFF_W'(8)) && (i_block_offset[2:0] == 3'd0)
                      && (w_offw < w_len);
    assign w_oidx   = w_offw[3 +: IW] - IW'(1);
    assign w_rnd    = (RND_W'(i_req_size) + RND_W'(7)) & ~RND_W'(7);
    assign w_blen   = i_rdata & LEN_MASK;
    assign w_fit    = !i_rdata[0] && (RND_W'(w_blen) >= r_rnd);
    assign w_rem    = w_blen - r_rnd[HDR_W-1:0];
    assign w_sum    = (PW+1)'(r_pos) + (PW+1)'(8) + (PW+1)'(r_rnd);

    always_comb begin
        n_state    = r_state;
        n_type     = r_type;
        n_rnd      = r_rnd;
        n_oidx     = r_oidx;
        n_have_old = r_have_old;
        n_move     = r_move;
        n_pos      = r_pos;
        n_sidx     = r_sidx;
        n_sval     = r_sval;
        n_res      = r_res;
        n_copy     = r_copy;
        n_status   = r_status;
        n_clr      = r_clr;
        o_ready    = 1'b0;
        o_done     = 1'b0;
        o_we       = 1'b0;
        o_waddr    = r_pos[3 +: IW];
        o_wdata    = '0;
        o_raddr    = r_pos[3 +: IW];
        case (r_state)
            S_CLR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                n_clr   = r_clr + IW'(1);
                if (r_clr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                o_raddr = w_oidx;
                if (i_valid) begin
                    n_type     = i_req_type;
                    n_rnd      = w_rnd;
                    n_oidx     = w_oidx;
                    n_have_old = 1'b0;
                    n_move     = '0;
                    n_pos      = '0;
                    n_res      = '0;
                    n_copy     = '0;
                    n_status   = ST_OK;
                    n_state    = S_FIN;
                    case (i_req_type)
                        REQ_INIT: begin
                            if (w_len < PW'(16)) begin
                                n_status = ST_TOO_SMALL;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = '0;
                                o_wdata = HDR_W'(w_len - PW'(8)) & LEN_MASK;
                            end
                        end
                        REQ_ALLOC, REQ_CHECK: begin
                            n_state = S_WALK;
                        end
                        REQ_FREE: begin
                            if (w_off_ok) begin
                                n_state = S_REL_WR;
                            end
                        end
                        REQ_REALLOC: begin
                            n_have_old = w_off_ok;
                            n_state    = w_off_ok ? S_OLD_EV : S_WALK;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_OLD_EV: begin
                n_move  = (RND_W'(w_blen) <= r_rnd) ? w_blen : r_rnd[HDR_W-1:0];
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_pos >= w_len) begin
                    if (r_type == REQ_CHECK) begin
                        n_status = (r_pos == w_len) ? ST_OK : ST_CORRUPT;
                    end else begin
                        n_status = ST_NO_SPACE;
                    end
                    n_state = S_FIN;
                end else begin
                    n_state = S_WEVAL;
                end
            end
            S_WEVAL: begin
                if (r_type == REQ_CHECK) begin
                    if (i_rdata[2:0] > 3'd1) begin
                        n_status = ST_CORRUPT;
                        n_state  = S_FIN;
                    end else begin
                        n_pos   = r_pos + PW'(8) + PW'(w_blen);
                        n_state = S_WALK;
                    end
                end else if (w_fit) begin
                    o_we    = 1'b1;
                    n_res   = OFF_W'(r_pos + PW'(8));
                    n_sidx  = w_sum[3 +: IW];
                    n_sval  = (w_rem - HDR_W'(8)) & LEN_MASK;
                    if (r_have_old) begin
                        n_copy = OFF_W'(r_move);
                    end
                    if (w_rem < MIN_SPLIT) begin
                        o_wdata = w_blen | HDR_W'(1);
                        n_state = r_have_old ? S_REL_RD : S_FIN;
                    end else begin
                        o_wdata = r_rnd[HDR_W-1:0] | HDR_W'(1);
                        if (w_sum < CAP_W) begin
                            n_state = S_SPLIT;
                        end else begin
                            n_state = r_have_old ? S_REL_RD : S_FIN;
                        end
                    end
                end else begin
                    n_pos   = r_pos + PW'(8) + PW'(w_blen);
                    n_state = S_WALK;
                end
            end
            S_SPLIT: begin
                o_we    = 1'b1;
                o_waddr = r_sidx;
                o_wdata = r_sval;
                n_state = r_have_old ? S_REL_RD : S_FIN;
            end
            S_REL_RD: begin
                o_raddr = r_oidx;
                n_state = S_REL_WR;
            end
            S_REL_WR: begin
                o_we    = 1'b1;
                o_waddr = r_oidx;
                o_wdata = i_rdata ^ HDR_W'(1);
                n_state = S_FIN;
            end
            S_FIN: begin
                o_done = 1'b1;
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_type     <= n_type;
        r_rnd      <= n_rnd;
        r_oidx     <= n_oidx;
        r_have_old <= n_have_old;
        r_move     <= n_move;
        r_pos      <= n_pos;
        r_sidx     <= n_sidx;
        r_sval     <= n_sval;
        r_res      <= n_res;
        r_copy     <= n_copy;
        r_status   <= n_status;
    end

    assign o_resp.result_offset = r_res;
    assign o_resp.copy_bytes    = r_copy;
    assign o_resp.status        = r_status;
endmodule

/* hw/rtl/implicit_list_heap_allocator_unit.sv */
// Top level of the first-fit heap allocator over an implicit header list.
//
// Request channel i_valid/o_ready carries req_type, req_size and block_offset;
// response channel o_valid/i_ready carries result_offset, copy_bytes, status.
// One response is returned for every request, in order.
// i_cfg_we/i_cfg_wdata write heap_size_bytes; write it only while idle.
// Headers live in a RAM of HEAP_WORDS entries with registered read.
// After reset a clearing pass zeros all HEAP_WORDS (1024 by default) RAM
// entries, one entry per cycle, with o_ready low. Per request: init, free
// and unknown types finish without a walk; allocate and check walk the
// block headers one by one; a split adds a write of the new header, a
// reallocate adds a read of the old header and a read and write to
// release it. The walk over the header RAM sets the rate.
// One request is in work at a time. A finished response sits in the output
// register; the next request is taken while it waits. If the receiver stalls,
// a second finished response waits in the sequencer until the register frees.
module implicit_list_heap_allocator_unit import ilha_pkg::*; #(
    parameter int HEAP_WORDS = HEAP_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_req_type,
    input  logic [SIZE_W-1:0] i_req_size,
    input  logic [OFF_W-1:0]  i_block_offset,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OFF_W-1:0]  o_result_offset,
    output logic [OFF_W-1:0]  o_copy_bytes,
    output logic [1:0]        o_status,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);
    localparam int IW = $clog2(HEAP_WORDS);

    logic [CFG_W-1:0] r_cfg;
    logic             r_ovalid;
    t_resp            r_out;
    logic             w_slot_free, w_done;
    t_resp            w_resp;
    logic             w_we;
    logic [IW-1:0]    w_waddr, w_raddr;
    logic [HDR_W-1:0] w_wdata, w_rdata;

    assign w_slot_free = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= CFG_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (w_done && w_slot_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (w_done && w_slot_free) begin
            r_out <= w_resp;
        end
    end

    ilha_ram #(.W(HDR_W), .D(HEAP_WORDS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ilha_core #(.HEAP_WORDS(HEAP_WORDS)) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_req_size     (i_req_size),
        .i_block_offset (i_block_offset),
        .i_cfg_len      (r_cfg),
        .i_slot_free    (w_slot_free),
        .o_done         (w_done),
        .o_resp         (w_resp),
        .o_we           (w_we),
        .o_waddr        (w_waddr),
        .o_wdata        (w_wdata),
        .o_raddr        (w_raddr),
        .i_rdata        (w_rdata)
    );

    assign o_valid         = r_ovalid;
    assign o_result_offset = r_out.result_offset;
    assign o_copy_bytes    = r_out.copy_bytes;
    assign o_status        = r_out.status;
endmodule

/* hw/rtl/ilha_chk.sv */
// Port-level checker for the heap allocator, bound to the top level.
module ilha_chk import ilha_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic [OFF_W-1:0]  o_result_offset,
    input logic [OFF_W-1:0]  o_copy_bytes,
    input logic [1:0]        o_status
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_offset)
            && $stable(o_copy_bytes) && $stable(o_status))
        else $error("response changed while stalled");

    a_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_copy_bytes != '0) |-> (o_status == ST_OK))
        else $error("copy length on a failed request");

    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_result_offset == '0) && (o_copy_bytes == '0))
        else $error("failed request returned an offset");

    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_offset != '0) |-> (o_result_offset[2:0] == 3'd0)
            && (o_result_offset >= OFF_W'(8)))
        else $error("granted offset misaligned");
endmodule

bind implicit_list_heap_allocator_unit ilha_chk u_ilha_chk (.*);

/* tb/tb.sv */
// Self-checking testbench for the first-fit heap allocator unit.
`timescale 1ns / 100ps

module tb;
    import ilha_pkg::*;

    localparam int          WORDS         = HEAP_WORDS_DEF;
    localparam int          CYCLE_LIMIT   = 20000000;
    localparam int          LONG_HOLD     = 400;
    localparam logic [2:0]  REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0]  REQ_UNUSED_HI = 3'd7;
    localparam int          RAND_PHASES   = 10;
    localparam int          PHASE_REQS    = 190;

    typedef struct {
        bit                is_cfg;
        logic [2:0]        ty;
        logic [SIZE_W-1:0] sz;
        logic [OFF_W-1:0]  off;
        bit                typed;
        t_resp             r;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [2:0]        i_req_type;
    logic [SIZE_W-1:0] i_req_size;
    logic [OFF_W-1:0]  i_block_offset;
    logic              o_valid;
    logic              i_ready;
    logic [OFF_W-1:0]  o_result_offset;
    logic [OFF_W-1:0]  o_copy_bytes;
    logic [1:0]        o_status;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_wdata;

    logic [HDR_W-1:0]  hdr_mem [WORDS];
    logic [CFG_W-1:0]  heap_cfg;
    t_resp             pending_resp[$];
    int                live_blocks[$];
    int                errors;
    int                cycles = 0;
    bit                calm;
    bit                long_hold;

    implicit_list_heap_allocator_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_req_size     (i_req_size),
        .i_block_offset (i_block_offset),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_offset(o_result_offset),
        .o_copy_bytes   (o_copy_bytes),
        .o_status       (o_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------- heap predictor ----------------
    function automatic int usable_len();
        int l;
        l = int'(heap_cfg) & int'(LEN_MASK);
        return (l < WORDS * 8) ? l : WORDS * 8;
    endfunction

    function automatic bit offset_valid(int off);
        return off >= 8 && (off % 8) == 0 && off < usable_len();
    endfunction

    function automatic int first_fit(int rounded);
        int len, pos, idx, blen, nidx;
        len = usable_len();
        pos = 0;
        while (pos < len) begin
            idx  = pos >> 3;
            blen = int'(hdr_mem[idx]) & int'(LEN_MASK);
            if (!hdr_mem[idx][0] && blen >= rounded) begin
                if (blen - rounded < 16) begin
                    hdr_mem[idx] = HDR_W'(blen | 1);
                end else begin
                    nidx = (pos + 8 + rounded) >> 3;
                    hdr_mem[idx] = HDR_W'(rounded | 1);
                    if (nidx < WORDS)
                        hdr_mem[nidx] = HDR_W'(blen - rounded - 8) & LEN_MASK;
                end
                return pos + 8;
            end
            pos = pos + 8 + blen;
        end
        return 0;
    endfunction

    function automatic void toggle_used(int off);
        if (offset_valid(off))
            hdr_mem[(off - 8) >> 3][0] = ~hdr_mem[(off - 8) >> 3][0];
    endfunction

    function automatic bit walk_sound();
        int len, pos, blen, total;
        len = usable_len();
        pos = 0;
        total = 0;
        while (pos < len) begin
            if (hdr_mem[pos >> 3][2:0] > 3'd1)
                return 1'b0;
            blen = int'(hdr_mem[pos >> 3]) & int'(LEN_MASK);
            total += 8 + blen;
            pos = pos + 8 + blen;
        end
        return total == len;
    endfunction

    function automatic t_resp heap_request(logic [2:0] ty, int sz, int off);
        t_resp r;
        int rounded, prev, move, res;
        bit have_old;
        r = '0;
        rounded = (sz + 7) & ~7;
        case (ty)
            REQ_INIT: begin
                if (usable_len() < 16)
                    r.status = ST_TOO_SMALL;
                else
                    hdr_mem[0] = HDR_W'(usable_len() - 8) & LEN_MASK;
            end
            REQ_ALLOC: begin
                res = first_fit(rounded);
                r.result_offset = OFF_W'(res);
                if (res == 0)
                    r.status = ST_NO_SPACE;
            end
            REQ_FREE: toggle_used(off);
            REQ_REALLOC: begin
                have_old = offset_valid(off);
                move = 0;
                if (have_old) begin
                    prev = int'(hdr_mem[(off - 8) >> 3]) & int'(LEN_MASK);
                    move = (prev <= rounded) ? prev : rounded;
                end
                res = first_fit(rounded);
                r.result_offset = OFF_W'(res);
                if (res == 0) begin
                    r.status = ST_NO_SPACE;
                end else if (have_old) begin
                    r.copy_bytes = OFF_W'(move);
                    toggle_used(off);
                end
            end
            REQ_CHECK: if (!walk_sound()) r.status = ST_CORRUPT;
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- driving ----------------
    task automatic report(string what, int got, int want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic wait_drained();
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_heap_size(logic [CFG_W-1:0] v);
        i_valid <= 1'b0;
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        heap_cfg = v;
        live_blocks.delete();
    endtask

    task automatic send_req(logic [2:0] ty, logic [SIZE_W-1:0] sz, logic [OFF_W-1:0] off,
                            bit typed, t_resp want, output t_resp got);
        i_valid        <= 1'b1;
        i_req_type     <= ty;
        i_req_size     <= sz;
        i_block_offset <= off;
        do @(posedge i_clk); while (!o_ready);
        got = heap_request(ty, int'(sz), int'(off));
        pending_resp.push_back(typed ? want : got);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) return SIZE_W'($urandom_range(0, 64));
        if (p < 95) return SIZE_W'($urandom_range(0, 600));
        return SIZE_W'($urandom);
    endfunction

    function automatic logic [OFF_W-1:0] pick_live();
        int p;
        p = $urandom_range(0, 99);
        if (live_blocks.size() != 0 && p < 85)
            return OFF_W'(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
        if (p < 92) return '0;
        return OFF_W'($urandom);
    endfunction

    task automatic random_request();
        t_resp got;
        logic [OFF_W-1:0] off;
        logic [2:0] ty;
        int p;
        p = $urandom_range(0, 99);
        off = pick_live();
        if (p < 40) ty = REQ_ALLOC;
        else if (p < 65) ty = REQ_FREE;
        else if (p < 85) ty = REQ_REALLOC;
        else if (p < 95) ty = REQ_CHECK;
        else if (p < 98) ty = REQ_INIT;
        else ty = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        send_req(ty, pick_size(), off, 1'b0, '0, got);
        if (ty == REQ_INIT) live_blocks.delete();
        if (ty == REQ_FREE || (ty == REQ_REALLOC && got.status == ST_OK))
            foreach (live_blocks[k])
                if (live_blocks[k] == int'(off)) begin
                    live_blocks.delete(k);
                    break;
                end
        if ((ty == REQ_ALLOC || ty == REQ_REALLOC) && got.status == ST_OK)
            live_blocks.push_back(int'(got.result_offset));
    endtask

    // ---------------- receiver ----------------
    initial begin
        i_ready = 1'b0;
        @(posedge i_clk);
        i_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold = 1'b0;
                i_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_resp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_resp.size() == 0) begin
                report("unexpected response", 0, 0);
            end else begin
                want = pending_resp.pop_front();
                if (o_result_offset != want.result_offset)
                    report("result_offset", o_result_offset, want.result_offset);
                if (o_copy_bytes != want.copy_bytes)
                    report("copy_bytes", o_copy_bytes, want.copy_bytes);
                if (o_status != want.status)
                    report("status", o_status, want.status);
            end
        end
    end

    // ---------------- stimulus ----------------
    t_row directed [] = '{
        '{1'b1, REQ_INIT,    16'd8192, 13'd0,    1'b0, '0},
        '{1'b0, REQ_CHECK,   16'd0,    13'd0,    1'b1, '{13'd0, 13'd0, ST_OK}},
        '{1'b0, REQ_ALLOC,   16'd0,    13'd0,    1'b1, '{13'd8, 13'd0, ST_OK}},
        '{1'b0, REQ_INIT,    16'd0,    13'd0,    1'b1, '{13'd0, 13'd0, ST_OK}},
        '{1'b0, REQ_ALLOC,   16'hFFFF, 13'd0,    1'b1, '{13'd0, 13'd0, ST_NO_SPACE}},
        '{1'b0, REQ_ALLOC,   16'd1,    13'd0,    1'b1, '{13'd8, 13'd0, ST_OK}},
        '{1'b0, REQ_ALLOC,   16'd100,  13'd0,    1'b0, '0},
        '{1'b0, REQ_ALLOC,   16'd0,    13'd0,    1'b0, '0},
        '{1'b0, REQ_FREE,    16'd0,    13'd3,    1'b1, '{13'd0, 13'd0, ST_OK}},
        '{1'b0, REQ_FREE,    16'd0,    13'd0,    1'b1, '{13'd0, 13'd0, ST_OK}},
        '{1'b0, REQ_FREE,    16'hFFFF, 13'h1FFF, 1'b1, '{13'd0, 13'd0, ST_OK}},
        '{1'b0, REQ_FREE,    16'd0,    13'd8,    1'b1, '{13'd0, 13'd0, ST_OK}},
        '{1'b0, REQ_REALLOC, 16'd40,   13'd0,    1'b0, '0},
        '{1'b0, REQ_REALLOC, 16'd200,  13'd24,   1'b0, '0},
        '{1'b0, REQ_REALLOC, 16'hFFFF, 13'd24,   1'b1, '{13'd0, 13'd0, ST_NO_SPACE}},
        '{1'b0, REQ_CHECK,   16'd0,    13'd0,    1'b0, '0},
        '{1'b0, REQ_UNUSED_LO, 16'hFFFF, 13'h1FFF, 1'b1, '{13'd0, 13'd0, ST_OK}},
        '{1'b0, REQ_UNUSED_HI, 16'd5,  13'd8,    1'b1, '{13'd0, 13'd0, ST_OK}},
        '{1'b0, REQ_INIT,    16'd0,    13'd0,    1'b1, '{13'd0, 13'd0, ST_OK}},
        '{1'b0, REQ_ALLOC,   16'd8176, 13'd0,    1'b1, '{13'd8, 13'd0, ST_OK}},
        '{1'b0, REQ_REALLOC, 16'd0,    13'd8191, 1'b1, '{13'd0, 13'd0, ST_NO_SPACE}},
        '{1'b1, REQ_INIT,    16'd15,   13'd0,    1'b0, '0},
        '{1'b0, REQ_INIT,    16'd0,    13'd0,    1'b1, '{13'd0, 13'd0, ST_TOO_SMALL}},
        '{1'b1, REQ_INIT,    16'd16,   13'd0,    1'b0, '0},
        '{1'b0, REQ_INIT,    16'd0,    13'd0,    1'b1, '{13'd0, 13'd0, ST_OK}},
        '{1'b0, REQ_ALLOC,   16'd8,    13'd0,    1'b1, '{13'd8, 13'd0, ST_OK}},
        '{1'b0, REQ_CHECK,   16'd0,    13'd0,    1'b1, '{13'd0, 13'd0, ST_OK}}
    };

    logic [CFG_W-1:0] phase_size [RAND_PHASES] = '{
        14'd8192, 14'd1000, 14'd16, 14'd4096, 14'd200,
        14'd8191, 14'd64, 14'd2048, 14'h3FFF, 14'd1024
    };

    initial begin
        t_resp got;
        errors         = 0;
        calm           = 1'b0;
        long_hold      = 1'b0;
        heap_cfg       = CFG_RESET;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_req_type     = '0;
        i_req_size     = '0;
        i_block_offset = '0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        foreach (hdr_mem[k]) hdr_mem[k] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            if (directed[k].is_cfg)
                write_heap_size(CFG_W'(directed[k].sz));
            else
                send_req(directed[k].ty, directed[k].sz, directed[k].off,
                         directed[k].typed, directed[k].r, got);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            i_valid <= 1'b0;
            write_heap_size(phase_size[ph]);
            if (ph == 3) long_hold = 1'b1;
            if ($urandom_range(0, 9) < 7)
                send_req(REQ_INIT, pick_size(), '0, 1'b0, '0, got);
            for (int n = 0; n < PHASE_REQS; n++) begin
                if (ph == RAND_PHASES - 1 && n > PHASE_REQS / 3) calm = 1'b1;
                random_request();
            end
        end
        i_valid <= 1'b0;

        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
